// ===== sv/assert_macros.svh =====
// assertion macros shared by the sharpen filter rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property, disabled while reset is asserted
`define SHC_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("shconv assertion failed");

// condition in one cycle implies expectation in the next
`define SHC_ASSERT_NEXT(name, clk, rstn, cond, nxt) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("shconv assertion failed");

`else

`define SHC_ASSERT(name, clk, rstn, prop)
`define SHC_ASSERT_NEXT(name, clk, rstn, cond, nxt)

`endif

`endif

// ===== sv/shconv_pkg.sv =====
// types and constants for the 3x3 sharpen filter
// no dependencies; imported by every module of the block but shconv_ram
package shconv_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int IN_PIXEL_W = 8;
    localparam int FILT_W     = 13;
    localparam int POS_W      = 7;
    localparam int CFG_W      = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int NUM_RES    = 4;

    localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

    // register index codes, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [IN_PIXEL_W-1:0] pixel;
        logic                  frame_start;
    } in_word_t;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic [POS_W-1:0]         out_row;
        logic [POS_W-1:0]         out_col;
        logic                     frame_last;
    } out_word_t;

    // position flags of the pixel held in the compute stage
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic right;
        logic bottom;
    } kern_ctl_t;

endpackage

// ===== sv/sharpen_convolution_3x3.sv =====
// 3x3 sharpen filter: one pixel word accepted per clock unless stalled, position counters
// at the input; the output stage registers a pixel's results as it leaves the compute stage
// one output port, so a pixel that completes n results holds the input until all are sent:
// 2 in the right column below row 0 and on the last row, 4 at the end
// reset: synchronous; the line store ram is then cleared word by word, no pixel taken meanwhile
// depends on shconv_pkg, shconv_line_buf, shconv_kernel, shconv_emit, assert_macros.svh
`include "assert_macros.svh"

module sharpen_convolution_3x3
    import shconv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] wlast;
    logic [ROW_W-1:0] hlast;
    logic             reg_idx;

    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic             restart;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic             cur_right, cur_bottom;
    logic             acc;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_W-1:0]      s1_c_reg;
    logic [POS_W-1:0]      s1_row_reg, s1_col_reg;
    kern_ctl_t             s1_ctl_reg;
    logic                  s1_adv;

    logic [PIXEL_BITS-1:0] up, lo;
    logic                  clr_busy;
    out_word_t             res [NUM_RES];
    logic [NUM_RES-1:0]    res_mask;
    logic                  emit_free;

    logic                  s1_stall;
    logic                  pos_origin;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(height_reg);
        endcase
    end

    // last column and row after saturating the sizes
    always_comb begin
        if (width_reg < CFG_W'(2)) begin
            wlast = COL_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            wlast = COL_W'(MAX_WIDTH - 1);
        end else begin
            wlast = COL_W'(width_reg - CFG_W'(1));
        end
        if (height_reg < CFG_W'(2)) begin
            hlast = ROW_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            hlast = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            hlast = ROW_W'(height_reg - CFG_W'(1));
        end
    end

    // position of the incoming pixel
    assign restart    = s_data.frame_start || (row_pos_reg > hlast) || (col_pos_reg > wlast);
    assign cur_row    = restart ? '0 : row_pos_reg;
    assign cur_col    = restart ? '0 : col_pos_reg;
    assign cur_right  = (cur_col == wlast);
    assign cur_bottom = (cur_row == hlast);

    always_comb begin
        if (cur_right) begin
            col_pos_next = '0;
            row_pos_next = cur_bottom ? '0 : cur_row + ROW_W'(1);
        end else begin
            col_pos_next = cur_col + COL_W'(1);
            row_pos_next = cur_row;
        end
    end

    assign s1_adv  = s1_valid_reg && emit_free;
    assign s_ready = !clr_busy && (!s1_valid_reg || s1_adv);
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (acc) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_pix_reg         <= PIXEL_BITS'(s_data.pixel);
            s1_c_reg           <= cur_col;
            s1_row_reg         <= POS_W'(cur_row);
            s1_col_reg         <= POS_W'(cur_col);
            s1_ctl_reg.row_ge1 <= (cur_row != '0);
            s1_ctl_reg.row_ge2 <= (cur_row > ROW_W'(1));
            s1_ctl_reg.col_ge1 <= (cur_col != '0);
            s1_ctl_reg.col_ge2 <= (cur_col > COL_W'(1));
            s1_ctl_reg.right   <= cur_right;
            s1_ctl_reg.bottom  <= cur_bottom;
        end
    end

    shconv_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (acc),
        .rd_addr  (cur_col),
        .wr_en    (s1_adv),
        .wr_addr  (s1_c_reg),
        .wr_upper (lo),
        .wr_lower (s1_pix_reg),
        .rd_upper (up),
        .rd_lower (lo),
        .clr_busy (clr_busy)
    );

    shconv_kernel #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_kernel (
        .aclk     (aclk),
        .shift_en (s1_adv),
        .up       (up),
        .lo       (lo),
        .pix      (s1_pix_reg),
        .ctl      (s1_ctl_reg),
        .row      (s1_row_reg),
        .col      (s1_col_reg),
        .res      (res),
        .res_mask (res_mask)
    );

    shconv_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s1_adv),
        .res      (res),
        .res_mask (res_mask),
        .free     (emit_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign s1_stall   = s1_valid_reg && !s1_adv;
    assign pos_origin = (row_pos_reg == '0) && (col_pos_reg == '0);

    // a stalled pixel keeps its place and its ram word
    `SHC_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_stall, s1_valid_reg && $stable(s1_c_reg))
    // nothing reaches the compute stage while the ram is being cleared
    `SHC_ASSERT(a_clear_empty, aclk, aresetn, clr_busy |-> !s1_valid_reg)
    // the last pixel of a frame wraps the counters to the origin
    `SHC_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, acc && cur_right && cur_bottom, pos_origin)

endmodule

// ===== sv/shconv_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// read returns the old word when reading and writing the same address
module shconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/shconv_line_buf.sv =====
// two line stores kept side by side in one ram word {upper, lower}
// depends on shconv_pkg and shconv_ram; zeroes the ram after reset
module shconv_line_buf
    import shconv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [PIXEL_BITS-1:0]        wr_upper,
    input  logic [PIXEL_BITS-1:0]        wr_lower,
    output logic [PIXEL_BITS-1:0]        rd_upper,
    output logic [PIXEL_BITS-1:0]        rd_lower,
    output logic                         clr_busy
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WORD_W = 2 * PIXEL_BITS;
    localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_WIDTH - 1);

    logic              clr_busy_reg;
    logic [COL_W-1:0]  clr_addr_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = wr_en;
            ram_waddr = wr_addr;
            ram_wdata = {wr_upper, wr_lower};
        end
    end

    // the ram reads the old word when a write to the same entry lands at that edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= ram_we && (ram_waddr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_word_reg <= ram_wdata;
        end
    end

    shconv_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign word     = fwd_hit_reg ? fwd_word_reg : ram_rdata;
    assign rd_upper = word[WORD_W-1:PIXEL_BITS];
    assign rd_lower = word[PIXEL_BITS-1:0];
    assign clr_busy = clr_busy_reg;

endmodule

// ===== sv/shconv_kernel.sv =====
// column window and the four candidate sharpen results of one pixel
// depends on shconv_pkg; window shifts when the pixel leaves the stage
module shconv_kernel
    import shconv_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [PIXEL_BITS-1:0] up,
    input  logic [PIXEL_BITS-1:0] lo,
    input  logic [PIXEL_BITS-1:0] pix,
    input  kern_ctl_t             ctl,
    input  logic [POS_W-1:0]      row,
    input  logic [POS_W-1:0]      col,
    output out_word_t             res [NUM_RES],
    output logic [NUM_RES-1:0]    res_mask
);

    localparam int ACC_W = PIXEL_BITS + 5;

    // columns c-2 and c-1, rows r-2, r-1, r
    logic [PIXEL_BITS-1:0] win_reg [6];
    logic [ACC_W-1:0]      g [3][3];
    logic [ACC_W-1:0]      tot_a, tot_b, tot_c, tot_d;
    logic [ACC_W-1:0]      val_a, val_b, val_c, val_d;

    function automatic logic [ACC_W-1:0] times10(input logic [ACC_W-1:0] v);
        return (v << 3) + (v << 1);
    endfunction

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up;
            win_reg[4] <= lo;
            win_reg[5] <= pix;
        end
    end

    // g[col][row], out-of-frame taps forced to zero
    always_comb begin
        for (int y = 0; y < 3; y++) begin
            g[0][y] = ACC_W'(win_reg[y]);
            g[1][y] = ACC_W'(win_reg[3 + y]);
        end
        g[2][0] = ACC_W'(up);
        g[2][1] = ACC_W'(lo);
        g[2][2] = ACC_W'(pix);
        for (int x = 0; x < 3; x++) begin
            if (!ctl.row_ge2) g[x][0] = '0;
            if (!ctl.row_ge1) g[x][1] = '0;
        end
        for (int y = 0; y < 3; y++) begin
            if (!ctl.col_ge2) g[0][y] = '0;
            if (!ctl.col_ge1) g[1][y] = '0;
        end
    end

    always_comb begin
        tot_a = '0;
        tot_b = '0;
        tot_c = '0;
        tot_d = '0;
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                tot_a = tot_a + g[x][y];
                if (x > 0) tot_b = tot_b + g[x][y];
                if (y > 0) tot_c = tot_c + g[x][y];
                if (x > 0 && y > 0) tot_d = tot_d + g[x][y];
            end
        end
        val_a = times10(g[1][1]) - tot_a;
        val_b = times10(g[2][1]) - tot_b;
        val_c = times10(g[1][2]) - tot_c;
        val_d = times10(g[2][2]) - tot_d;
    end

    assign res[0] = '{filtered: FILT_W'(val_a), out_row: row - POS_W'(1),
                      out_col: col - POS_W'(1), frame_last: 1'b0};
    assign res[1] = '{filtered: FILT_W'(val_b), out_row: row - POS_W'(1),
                      out_col: col, frame_last: 1'b0};
    assign res[2] = '{filtered: FILT_W'(val_c), out_row: row,
                      out_col: col - POS_W'(1), frame_last: 1'b0};
    assign res[3] = '{filtered: FILT_W'(val_d), out_row: row,
                      out_col: col, frame_last: 1'b1};

    assign res_mask[0] = ctl.row_ge1 && ctl.col_ge1;
    assign res_mask[1] = ctl.row_ge1 && ctl.right;
    assign res_mask[2] = ctl.bottom && ctl.col_ge1;
    assign res_mask[3] = ctl.bottom && ctl.right;

endmodule

// ===== sv/shconv_emit.sv =====
// output stage: holds up to four results of one pixel, sends one word a cycle while m_ready is high
// depends on shconv_pkg
module shconv_emit
    import shconv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  out_word_t          res [NUM_RES],
    input  logic [NUM_RES-1:0] res_mask,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data
);

    out_word_t          slot_reg [NUM_RES];
    logic [NUM_RES-1:0] mask_reg;
    logic [NUM_RES-1:0] mask_rest;
    logic               last_one;

    // mask with its lowest set bit removed
    assign mask_rest = mask_reg & (mask_reg - NUM_RES'(1));
    assign last_one  = (mask_rest == '0);
    assign m_valid   = (mask_reg != '0);
    assign free      = !m_valid || (last_one && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (load) begin
            mask_reg <= res_mask;
        end else if (m_valid && m_ready) begin
            mask_reg <= mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= res;
        end
    end

    always_comb begin
        priority if (mask_reg[0]) begin
            m_data = slot_reg[0];
        end else if (mask_reg[1]) begin
            m_data = slot_reg[1];
        end else if (mask_reg[2]) begin
            m_data = slot_reg[2];
        end else begin
            m_data = slot_reg[3];
        end
    end

endmodule

// ===== tb/sharpen_convolution_3x3_checker.sv =====
// checker for the 3x3 sharpen filter: watches the pixel, result and register ports,
// predicts every output word and compares it field by field
// depends on shconv_pkg for the word types, sizes and register codes
module sharpen_convolution_3x3_checker
    import shconv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_word_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_word_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]          width_reg;
    logic [CFG_W-1:0]          height_reg;
    logic [DEF_PIXEL_BITS-1:0] upper_line [DEF_MAX_WIDTH];
    logic [DEF_PIXEL_BITS-1:0] lower_line [DEF_MAX_WIDTH];
    // columns c-2 and c-1, each rows r-2, r-1, r
    logic [DEF_PIXEL_BITS-1:0] win [6];
    int unsigned               row_pos;
    int unsigned               col_pos;
    // nbhd[col][row]: col 0..2 = c-2..c, row 0..2 = r-2..r, index 3 is zero padding
    int                        nbhd [4][4];
    out_word_t                 sharpened_q [$];
    out_word_t                 want;
    int                        fails = 0;
    int                        n_checked = 0;

    function automatic int unsigned limit_size(logic [CFG_W-1:0] raw, int unsigned hi);
        if (raw < 2) return 2;
        if (raw > hi) return hi;
        return 32'(raw);
    endfunction

    function automatic void queue_result(int ci, int ri, int unsigned row, int unsigned col,
                                         bit last);
        out_word_t word;
        int        x, y, total, value;
        total = 0;
        for (x = 0; x < 3; x++) begin
            for (y = 0; y < 3; y++) begin
                total += nbhd[ci + x][ri + y];
            end
        end
        value = 10 * nbhd[ci + 1][ri + 1] - total;
        word.filtered   = value[FILT_W-1:0];
        word.out_row    = row[POS_W-1:0];
        word.out_col    = col[POS_W-1:0];
        word.frame_last = last;
        sharpened_q.push_back(word);
    endfunction

    function automatic void sharpen_pixel(in_word_t word);
        int unsigned               wd, ht, r, c;
        logic [DEF_PIXEL_BITS-1:0] up, lo, pix;
        bit                        right, bottom;
        int                        x, y;
        wd  = limit_size(width_reg, DEF_MAX_WIDTH);
        ht  = limit_size(height_reg, DEF_MAX_HEIGHT);
        pix = word.pixel & DEF_PIXEL_BITS'((1 << DEF_PIXEL_BITS) - 1);
        // frame start, or a size change that left the counters outside the frame
        if (word.frame_start || row_pos >= ht || col_pos >= wd) begin
            row_pos = 0;
            col_pos = 0;
        end
        r  = row_pos;
        c  = col_pos;
        up = upper_line[c];
        lo = lower_line[c];

        for (x = 0; x < 4; x++) begin
            for (y = 0; y < 4; y++) begin
                nbhd[x][y] = 0;
            end
        end
        for (y = 0; y < 3; y++) begin
            nbhd[0][y] = int'(win[y]);
            nbhd[1][y] = int'(win[3 + y]);
        end
        nbhd[2][0] = int'(up);
        nbhd[2][1] = int'(lo);
        nbhd[2][2] = int'(pix);
        // stale rows above the top and columns left of the edge read as zero
        for (x = 0; x < 3; x++) begin
            if (r < 2) nbhd[x][0] = 0;
            if (r < 1) nbhd[x][1] = 0;
        end
        for (y = 0; y < 3; y++) begin
            if (c < 2) nbhd[0][y] = 0;
            if (c < 1) nbhd[1][y] = 0;
        end

        right  = (c == wd - 1);
        bottom = (r == ht - 1);
        if (r >= 1) begin
            if (c >= 1) queue_result(0, 0, r - 1, c - 1, 1'b0);
            if (right) queue_result(1, 0, r - 1, c, 1'b0);
        end
        if (bottom) begin
            if (c >= 1) queue_result(0, 1, r, c - 1, 1'b0);
            if (right) queue_result(1, 1, r, c, 1'b1);
        end

        for (y = 0; y < 3; y++) begin
            win[y] = win[3 + y];
        end
        win[3]        = up;
        win[4]        = lo;
        win[5]        = pix;
        upper_line[c] = lo;
        lower_line[c] = pix;

        if (right) begin
            col_pos = 0;
            row_pos = bottom ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = SIZE_RESET;
            height_reg = SIZE_RESET;
            for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            for (int i = 0; i < 6; i++) begin
                win[i] = '0;
            end
            row_pos = 0;
            col_pos = 0;
            sharpened_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_FRAME_HEIGHT) begin
                    height_reg = pwdata[CFG_W-1:0];
                end else begin
                    width_reg = pwdata[CFG_W-1:0];
                end
            end
            if (m_valid && m_ready) begin
                n_checked++;
                if (sharpened_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word row %0d col %0d filtered %0d",
                             $time, m_data.out_row, m_data.out_col, $signed(m_data.filtered));
                end else begin
                    want = sharpened_q.pop_front();
                    if (m_data !== want) begin
                        fails++;
                        if (m_data.filtered !== want.filtered)
                            $display("%0t: filtered mismatch: expected %0d, got %0d", $time,
                                     $signed(want.filtered), $signed(m_data.filtered));
                        if (m_data.out_row !== want.out_row)
                            $display("%0t: out_row mismatch: expected %0d, got %0d", $time,
                                     want.out_row, m_data.out_row);
                        if (m_data.out_col !== want.out_col)
                            $display("%0t: out_col mismatch: expected %0d, got %0d", $time,
                                     want.out_col, m_data.out_col);
                        if (m_data.frame_last !== want.frame_last)
                            $display("%0t: frame_last mismatch: expected %0d, got %0d", $time,
                                     want.frame_last, m_data.frame_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                sharpen_pixel(s_data);
            end
        end
        // published after the edge so the stimulus side reads settled values
        fail_count <= fails;
        pending    <= sharpened_q.size();
        checked    <= n_checked;
    end

endmodule

// ===== tb/sharpen_convolution_3x3_test.sv =====
// top of the sharpen filter testbench: clock, reset, pixel and register stimulus, verdict
// depends on shconv_pkg, sharpen_convolution_3x3 and sharpen_convolution_3x3_checker
module sharpen_convolution_3x3_test;
    timeunit 1ns;
    timeprecision 1ps;
    import shconv_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 22;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pixels_sent   = 0;
    int settings_used = 0;

    sharpen_convolution_3x3 dut (.*);

    sharpen_convolution_3x3_checker result_check (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sharpen_convolution_3x3 test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input logic [IN_PIXEL_W-1:0] pixel, input logic start);
        in_word_t word;
        word.pixel       = pixel;
        word.frame_start = start;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic write_size(input logic reg_sel, input logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] word;
        // bits above the register are don't-care, so fill them with noise
        word            = $urandom;
        word[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // pixels that finish no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_frames(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h,
                              input int frame_px, input int n_items);
        logic [IN_PIXEL_W-1:0] pixel;
        logic                  start;
        int                    i;
        drain_results();
        write_size(REG_FRAME_WIDTH, raw_w);
        write_size(REG_FRAME_HEIGHT, raw_h);
        settings_used++;
        for (i = 0; i < n_items; i++) begin
            case ($urandom_range(3))
                0: pixel = '0;
                1: pixel = '1;
                default: pixel = IN_PIXEL_W'($urandom_range(255));
            endcase
            // frame boundaries usually marked, sometimes left to wrap; rare stray restarts
            if (i % frame_px == 0) begin
                start = ($urandom_range(3) != 0);
            end else begin
                start = ($urandom_range(49) == 0);
            end
            send_pixel(pixel, start);
        end
    endtask

    initial begin
        int               i, phase, phase_items, n, eff_w, eff_h;
        logic [CFG_W-1:0] raw_w, raw_h;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 48;
        write_size(REG_FRAME_WIDTH, 8'd3);
        write_size(REG_FRAME_HEIGHT, 8'd3);
        settings_used++;
        // lone bright center gives the largest positive result
        for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0, i == 0);
        // dark center in a bright surround, entered by wrap-around only
        for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255, 1'b0);
        // restart in the middle of a row, then leave the counters at column 2
        send_pixel(8'd17, 1'b0);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd90, 1'b0);
        // sizes below range clamp to 2x2, column 2 now lies outside and the counters restart
        drain_results();
        write_size(REG_FRAME_WIDTH, 8'd1);
        write_size(REG_FRAME_HEIGHT, 8'd0);
        settings_used++;
        repeat (4) send_pixel(8'd255, 1'b0);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 48;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 2) begin
                // widest rows: top row plus a few pixels of the next, then a smaller
                // frame that leaves the counters outside
                run_frames(8'd255, 8'd200, DEF_MAX_WIDTH * DEF_MAX_HEIGHT, DEF_MAX_WIDTH + 4);
                run_frames(8'd3, 8'd2, 6, 12);
            end
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                eff_w = ($urandom_range(4) == 0) ? 2 : $urandom_range(8, 3);
                eff_h = ($urandom_range(4) == 0) ? 2 : $urandom_range(6, 3);
                raw_w = (eff_w == 2) ? CFG_W'($urandom_range(2)) : CFG_W'(eff_w);
                raw_h = (eff_h == 2) ? CFG_W'($urandom_range(2)) : CFG_W'(eff_h);
                n     = eff_w * eff_h * $urandom_range(2, 1);
                if ($urandom_range(9) == 0) begin
                    // tallest frame, only its first rows fed
                    raw_h = $urandom_range(1) ? 8'd128 : 8'd255;
                    eff_h = DEF_MAX_HEIGHT;
                    n     = $urandom_range(24, 6);
                end else if ($urandom_range(4) == 0) begin
                    n = $urandom_range(n, 1);
                end
                // the last run of a phase stops at the phase budget
                if (n > ITEMS_PER_PHASE - phase_items) begin
                    n = ITEMS_PER_PHASE - phase_items;
                end
                run_frames(raw_w, raw_h, eff_w * eff_h, n);
                phase_items += n;
            end
        end

        drain_results();
        $display("run covered %0d pixel words under %0d frame size settings (2 to 128 each way)",
                 pixels_sent, settings_used);
        $display("%0d filtered words compared under three handshake stall mixes", checked);
        if (fail_count == 0) begin
            $display("sharpen_convolution_3x3 test passed");
        end else begin
            $display("sharpen_convolution_3x3 test failed");
        end
        $finish;
    end

endmodule
